// ===== rtl/core/rvdec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvdec_pkg
// Shared types and codes of the RV32IM instruction decoder: opcodes,
// mnemonic codes, format codes and the decoded result record.
// ----------------------------------------------------------------------------
package rvdec_pkg;

    localparam int INSTR_W = 32;
    localparam int MNEM_W  = 6;
    localparam int FMT_W   = 3;
    localparam int REG_W   = 5;
    localparam int IMM_W   = 32;

    // Major opcodes.
    localparam logic [6:0] OPC_OP    = 7'h33;
    localparam logic [6:0] OPC_LOAD  = 7'h03;
    localparam logic [6:0] OPC_OPIMM = 7'h13;
    localparam logic [6:0] OPC_SYS   = 7'h73;
    localparam logic [6:0] OPC_STORE = 7'h23;
    localparam logic [6:0] OPC_BR    = 7'h63;
    localparam logic [6:0] OPC_LUI   = 7'h37;
    localparam logic [6:0] OPC_AUIPC = 7'h17;
    localparam logic [6:0] OPC_JAL   = 7'h6F;
    localparam logic [6:0] OPC_JALR  = 7'h67;

    // funct7 values of the register-register group.
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_MUL  = 7'h01;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // funct3 values.
    localparam logic [2:0] F3_0 = 3'd0;
    localparam logic [2:0] F3_1 = 3'd1;
    localparam logic [2:0] F3_2 = 3'd2;
    localparam logic [2:0] F3_3 = 3'd3;
    localparam logic [2:0] F3_4 = 3'd4;
    localparam logic [2:0] F3_5 = 3'd5;
    localparam logic [2:0] F3_6 = 3'd6;
    localparam logic [2:0] F3_7 = 3'd7;

    // System immediates.
    localparam logic [11:0] SYS_ECALL  = 12'h000;
    localparam logic [11:0] SYS_EBREAK = 12'h001;

    // Instruction formats.
    localparam logic [FMT_W-1:0] FMT_R    = 3'd0;
    localparam logic [FMT_W-1:0] FMT_I    = 3'd1;
    localparam logic [FMT_W-1:0] FMT_S    = 3'd2;
    localparam logic [FMT_W-1:0] FMT_B    = 3'd3;
    localparam logic [FMT_W-1:0] FMT_U    = 3'd4;
    localparam logic [FMT_W-1:0] FMT_J    = 3'd5;
    localparam logic [FMT_W-1:0] FMT_NONE = 3'd6;

    // Mnemonic codes.
    localparam logic [MNEM_W-1:0] MN_UNKNOWN = 6'd0;
    localparam logic [MNEM_W-1:0] MN_ADD    = 6'd1;
    localparam logic [MNEM_W-1:0] MN_MUL    = 6'd2;
    localparam logic [MNEM_W-1:0] MN_SUB    = 6'd3;
    localparam logic [MNEM_W-1:0] MN_SLL    = 6'd4;
    localparam logic [MNEM_W-1:0] MN_MULH   = 6'd5;
    localparam logic [MNEM_W-1:0] MN_SLT    = 6'd6;
    localparam logic [MNEM_W-1:0] MN_SLTU   = 6'd7;
    localparam logic [MNEM_W-1:0] MN_XOR    = 6'd8;
    localparam logic [MNEM_W-1:0] MN_DIV    = 6'd9;
    localparam logic [MNEM_W-1:0] MN_SRL    = 6'd10;
    localparam logic [MNEM_W-1:0] MN_SRA    = 6'd11;
    localparam logic [MNEM_W-1:0] MN_DIVU   = 6'd12;
    localparam logic [MNEM_W-1:0] MN_OR     = 6'd13;
    localparam logic [MNEM_W-1:0] MN_REM    = 6'd14;
    localparam logic [MNEM_W-1:0] MN_AND    = 6'd15;
    localparam logic [MNEM_W-1:0] MN_REMU   = 6'd16;
    localparam logic [MNEM_W-1:0] MN_LB     = 6'd17;
    localparam logic [MNEM_W-1:0] MN_LH     = 6'd18;
    localparam logic [MNEM_W-1:0] MN_LW     = 6'd19;
    localparam logic [MNEM_W-1:0] MN_LBU    = 6'd20;
    localparam logic [MNEM_W-1:0] MN_LHU    = 6'd21;
    localparam logic [MNEM_W-1:0] MN_ADDI   = 6'd22;
    localparam logic [MNEM_W-1:0] MN_SLLI   = 6'd23;
    localparam logic [MNEM_W-1:0] MN_SLTI   = 6'd24;
    localparam logic [MNEM_W-1:0] MN_SLTIU  = 6'd25;
    localparam logic [MNEM_W-1:0] MN_XORI   = 6'd26;
    localparam logic [MNEM_W-1:0] MN_SRLI   = 6'd27;
    localparam logic [MNEM_W-1:0] MN_SRAI   = 6'd28;
    localparam logic [MNEM_W-1:0] MN_ORI    = 6'd29;
    localparam logic [MNEM_W-1:0] MN_ANDI   = 6'd30;
    localparam logic [MNEM_W-1:0] MN_ECALL  = 6'd31;
    localparam logic [MNEM_W-1:0] MN_EBREAK = 6'd32;
    localparam logic [MNEM_W-1:0] MN_SB     = 6'd33;
    localparam logic [MNEM_W-1:0] MN_SH     = 6'd34;
    localparam logic [MNEM_W-1:0] MN_SW     = 6'd35;
    localparam logic [MNEM_W-1:0] MN_BEQ    = 6'd36;
    localparam logic [MNEM_W-1:0] MN_BNE    = 6'd37;
    localparam logic [MNEM_W-1:0] MN_BLT    = 6'd38;
    localparam logic [MNEM_W-1:0] MN_BGE    = 6'd39;
    localparam logic [MNEM_W-1:0] MN_BLTU   = 6'd40;
    localparam logic [MNEM_W-1:0] MN_BGEU   = 6'd41;
    localparam logic [MNEM_W-1:0] MN_LUI    = 6'd42;
    localparam logic [MNEM_W-1:0] MN_AUIPC  = 6'd43;
    localparam logic [MNEM_W-1:0] MN_JAL    = 6'd44;
    localparam logic [MNEM_W-1:0] MN_JALR   = 6'd45;

    typedef struct packed {
        logic [MNEM_W-1:0]       mnemonic;
        logic [FMT_W-1:0]        format;
        logic [REG_W-1:0]        rd_index;
        logic [REG_W-1:0]        rs1_index;
        logic [REG_W-1:0]        rs2_index;
        logic signed [IMM_W-1:0] immediate;
    } t_dec_result;

endpackage

// ===== rtl/core/rvdec_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvdec_in_if / rvdec_out_if
// Valid/ready channels of the decoder: instruction words in, decoded
// results out.
// ----------------------------------------------------------------------------
interface rvdec_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_word;

    modport source (output valid, output instr_word, input ready);
    modport sink   (input valid, input instr_word, output ready);
endinterface

interface rvdec_out_if;
    logic               valid;
    logic               ready;
    logic [5:0]         mnemonic;
    logic [2:0]         format;
    logic [4:0]         rd_index;
    logic [4:0]         rs1_index;
    logic [4:0]         rs2_index;
    logic signed [31:0] immediate;

    modport source (
        output valid, output mnemonic, output format, output rd_index,
        output rs1_index, output rs2_index, output immediate, input ready
    );
    modport sink (
        input valid, input mnemonic, input format, input rd_index,
        input rs1_index, input rs2_index, input immediate, output ready
    );
endinterface

// ===== rtl/core/rv32im_instruction_decoder_top.sv =====
`timescale 1ns / 1ps
// Throughput: one instruction word per cycle unless the output stalls; the
// input register and the result register form a two-stage pipeline that
// advances whenever the result register is empty or its transaction
// completes.
// Reset: synchronous, active low; clears both stage valid flags only.
// ----------------------------------------------------------------------------
// rv32im_instruction_decoder_top
// RV32IM instruction decoder: registers the instruction word, decodes it
// and registers the decoded result behind a valid/ready channel.
// ----------------------------------------------------------------------------
module rv32im_instruction_decoder_top
    import rvdec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rvdec_in_if.sink    i_instr,
    rvdec_out_if.source o_dec
);

    logic               r_in_valid;
    logic [INSTR_W-1:0] r_in_word;
    logic               r_out_valid;
    t_dec_result        r_out;
    t_dec_result        dec_result;
    logic               out_free;
    logic               in_free;

    // The result register can load when it is empty or being drained.
    assign out_free = !r_out_valid || o_dec.ready;
    assign in_free  = !r_in_valid || out_free;

    assign i_instr.ready = in_free;

    rvdec_decode u_decode (
        .i_word   (r_in_word),
        .o_result (dec_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_instr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_instr.valid) begin
            r_in_word <= i_instr.instr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid) begin
            r_out <= dec_result;
        end
    end

    assign o_dec.valid     = r_out_valid;
    assign o_dec.mnemonic  = r_out.mnemonic;
    assign o_dec.format    = r_out.format;
    assign o_dec.rd_index  = r_out.rd_index;
    assign o_dec.rs1_index = r_out.rs1_index;
    assign o_dec.rs2_index = r_out.rs2_index;
    assign o_dec.immediate = r_out.immediate;

endmodule

// ===== rtl/core/rvdec_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvdec_decode
// Combinational decode of one instruction word into mnemonic, format,
// register fields and the immediate of its format.
// ----------------------------------------------------------------------------
module rvdec_decode
    import rvdec_pkg::*;
(
    input  logic [INSTR_W-1:0] i_word,
    output t_dec_result        o_result
);

    logic [6:0]       opc;
    logic [2:0]       f3;
    logic [6:0]       f7;
    logic [IMM_W-1:0] imm_i;
    logic [IMM_W-1:0] imm_s;
    logic [IMM_W-1:0] imm_b;
    logic [IMM_W-1:0] imm_j;
    logic [IMM_W-1:0] imm_u;
    logic [IMM_W-1:0] shamt;
    logic [MNEM_W-1:0] mn;
    logic [FMT_W-1:0]  fmt;
    logic [IMM_W-1:0]  imm;

    assign opc   = i_word[6:0];
    assign f3    = i_word[14:12];
    assign f7    = i_word[31:25];
    assign imm_i = {{20{i_word[31]}}, i_word[31:20]};
    assign imm_s = {{20{i_word[31]}}, i_word[31:25], i_word[11:7]};
    assign imm_b = {{19{i_word[31]}}, i_word[31], i_word[7], i_word[30:25],
                    i_word[11:8], 1'b0};
    assign imm_j = {{11{i_word[31]}}, i_word[31], i_word[19:12], i_word[20],
                    i_word[30:21], 1'b0};
    assign imm_u = {i_word[31:12], 12'h000};
    assign shamt = {27'd0, i_word[24:20]};

    always_comb begin
        mn  = MN_UNKNOWN;
        fmt = FMT_NONE;
        imm = '0;
        unique case (opc)
            OPC_OP: begin
                fmt = FMT_R;
                unique case (f7)
                    F7_BASE: begin
                        unique case (f3)
                            F3_0:    mn = MN_ADD;
                            F3_1:    mn = MN_SLL;
                            F3_2:    mn = MN_SLT;
                            F3_3:    mn = MN_SLTU;
                            F3_4:    mn = MN_XOR;
                            F3_5:    mn = MN_SRL;
                            F3_6:    mn = MN_OR;
                            default: mn = MN_AND;
                        endcase
                    end
                    F7_MUL: begin
                        unique case (f3)
                            F3_0:    mn = MN_MUL;
                            F3_1:    mn = MN_MULH;
                            F3_4:    mn = MN_DIV;
                            F3_5:    mn = MN_DIVU;
                            F3_6:    mn = MN_REM;
                            F3_7:    mn = MN_REMU;
                            default: mn = MN_UNKNOWN;
                        endcase
                    end
                    F7_ALT: begin
                        unique case (f3)
                            F3_0:    mn = MN_SUB;
                            F3_5:    mn = MN_SRA;
                            default: mn = MN_UNKNOWN;
                        endcase
                    end
                    default: mn = MN_UNKNOWN;
                endcase
            end
            OPC_LOAD: begin
                fmt = FMT_I;
                imm = imm_i;
                unique case (f3)
                    F3_0:    mn = MN_LB;
                    F3_1:    mn = MN_LH;
                    F3_2:    mn = MN_LW;
                    F3_4:    mn = MN_LBU;
                    F3_5:    mn = MN_LHU;
                    default: mn = MN_UNKNOWN;
                endcase
            end
            OPC_OPIMM: begin
                fmt = FMT_I;
                imm = imm_i;
                unique case (f3)
                    F3_0: mn = MN_ADDI;
                    F3_1: begin
                        mn  = MN_SLLI;
                        imm = shamt;
                    end
                    F3_2: mn = MN_SLTI;
                    F3_3: mn = MN_SLTIU;
                    F3_4: mn = MN_XORI;
                    F3_5: begin
                        // Only bit 30 separates the arithmetic shift.
                        mn  = i_word[30] ? MN_SRAI : MN_SRLI;
                        imm = shamt;
                    end
                    F3_6:    mn = MN_ORI;
                    default: mn = MN_ANDI;
                endcase
            end
            OPC_SYS: begin
                fmt = FMT_I;
                imm = imm_i;
                if (f3 == F3_0 && i_word[31:20] == SYS_ECALL) begin
                    mn = MN_ECALL;
                end else if (f3 == F3_0 && i_word[31:20] == SYS_EBREAK) begin
                    mn = MN_EBREAK;
                end
            end
            OPC_STORE: begin
                fmt = FMT_S;
                imm = imm_s;
                unique case (f3)
                    F3_0:    mn = MN_SB;
                    F3_1:    mn = MN_SH;
                    F3_2:    mn = MN_SW;
                    default: mn = MN_UNKNOWN;
                endcase
            end
            OPC_BR: begin
                fmt = FMT_B;
                imm = imm_b;
                unique case (f3)
                    F3_0:    mn = MN_BEQ;
                    F3_1:    mn = MN_BNE;
                    F3_4:    mn = MN_BLT;
                    F3_5:    mn = MN_BGE;
                    F3_6:    mn = MN_BLTU;
                    F3_7:    mn = MN_BGEU;
                    default: mn = MN_UNKNOWN;
                endcase
            end
            OPC_LUI: begin
                mn  = MN_LUI;
                fmt = FMT_U;
                imm = imm_u;
            end
            OPC_AUIPC: begin
                mn  = MN_AUIPC;
                fmt = FMT_U;
                imm = imm_u;
            end
            OPC_JAL: begin
                mn  = MN_JAL;
                fmt = FMT_J;
                imm = imm_j;
            end
            OPC_JALR: begin
                mn  = MN_JALR;
                fmt = FMT_I;
                imm = imm_i;
            end
            default: mn = MN_UNKNOWN;
        endcase

        // Unrecognized words carry no format and no immediate.
        if (mn == MN_UNKNOWN) begin
            fmt = FMT_NONE;
            imm = '0;
        end
    end

    assign o_result.mnemonic  = mn;
    assign o_result.format    = fmt;
    assign o_result.rd_index  = i_word[11:7];
    assign o_result.rs1_index = i_word[19:15];
    assign o_result.rs2_index = i_word[24:20];
    assign o_result.immediate = imm;

endmodule
